[hw/rtl/ocp_pkg.sv]
// Package with the types, constants and sine table builder of the orbit camera position unit.
package ocp_pkg;

  localparam int ANGLE_W    = 12;
  localparam int SUM_W      = 21;
  localparam int POS_W      = 32;
  localparam int QUARTER    = 900;
  localparam int FULL_TURN  = 3600;
  localparam int WRAP_STEPS = 8;
  localparam int TABLE_AW   = 10;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [15:0]      ZOOM_STEP_RST  = 16'd3277;
  localparam logic [3:0]       PITCH_GAIN_RST = 4'd1;
  localparam logic [3:0]       ORBIT_GAIN_RST = 4'd3;
  localparam logic [POS_W-1:0] DISTANCE_RST   = 32'd655360;
  localparam logic [ANGLE_W-1:0] PITCH_RST    = 12'd200;
  localparam logic [ANGLE_W-1:0] ORBIT_RST    = 12'd0;

  typedef enum logic [1:0] {
    CFG_ZOOM_STEP,
    CFG_PITCH_GAIN,
    CFG_ORBIT_GAIN,
    CFG_START_DISTANCE
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_TRIG_P,
    ST_MUL_HV_GO,
    ST_MUL_HV,
    ST_TRIG_T,
    ST_MUL_T_GO,
    ST_MUL_T,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                  zoom_in_key;
    logic                  zoom_out_key;
    logic                  orbit_button;
    logic signed [15:0]    mouse_dx;
    logic signed [15:0]    mouse_dy;
    logic signed [31:0]    player_x;
    logic signed [31:0]    player_y;
    logic signed [31:0]    player_z;
    logic [ANGLE_W-1:0]    player_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic signed [31:0] camera_z;
  } out_t;

  // Quarter-wave sine entry: Taylor polynomial in Q30, rounded to frac bits and clamped to 1.0.
  function automatic logic [31:0] sine_entry(input int unsigned t, input int unsigned frac);
    logic [63:0] one;
    logic [63:0] full;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    one  = 64'd1 << 30;
    full = 64'd1 << frac;
    x    = (64'(t) * PI_Q30) / 64'd1800;
    x2   = (x * x) >> 30;
    r    = one;
    r    = one - (((r * x2) >> 30) / 64'd156);
    r    = one - (((r * x2) >> 30) / 64'd110);
    r    = one - (((r * x2) >> 30) / 64'd72);
    r    = one - (((r * x2) >> 30) / 64'd42);
    r    = one - (((r * x2) >> 30) / 64'd20);
    r    = one - (((r * x2) >> 30) / 64'd6);
    s = (x * r) >> 30;
    s = (s + (64'd1 << (29 - frac))) >> (30 - frac);
    if (s > full) begin
      s = full;
    end
    return s[31:0];
  endfunction

endpackage

[hw/rtl/orbit_camera_position_unit.sv]
// Top level of the orbit camera position unit.
// Usage: one input transfer per rendered frame carries the zoom keys, the orbit button,
// the mouse deltas and the player pose; each one gives exactly one output transfer with
// the camera position. Both channels use valid and stall; a transfer happens at a clock
// edge where valid is high and stall is low. Configuration registers are written through
// cfg_we_i, cfg_index_i and cfg_data_i; the user is to write them only while the unit
// is idle, which the unit itself does not enforce. Writing the start distance also
// reloads the orbit distance at once.
// Sequence: the angle reduction and the angle update come first, then two passes through
// the pair of bit-serial multipliers, one multiplier bit per cycle. One item is in work
// at a time; the next one is taken in the cycle after the result is loaded into the
// output register.
// Reset: the registers return to their default values, the orbit distance to the start
// distance, the pitch to 20 degrees and the orbit angle to zero; no result is pending.
// Output stall: the result waits in the output register. A new item is still accepted,
// and its result waits in the last step until the output register is free.
module orbit_camera_position_unit #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [30:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ocp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ocp_pkg::out_t  out_data_o
);
  import ocp_pkg::*;

  localparam int SW = TRIG_FRAC_BITS + 2;

  function automatic logic [ANGLE_W-1:0] add_quarter(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] r;
    if (a >= ANGLE_W'(FULL_TURN - QUARTER)) begin
      r = a - ANGLE_W'(FULL_TURN - QUARTER);
    end else begin
      r = a + ANGLE_W'(QUARTER);
    end
    return r;
  endfunction

  state_e state_q;
  state_e state_d;

  logic [15:0]              zoom_step_q;
  logic [3:0]               pitch_gain_q;
  logic [3:0]               orbit_gain_q;
  logic signed [POS_W-1:0]  dist_q;
  logic [ANGLE_W-1:0]       pitch_q;
  logic [ANGLE_W-1:0]       orbit_q;
  logic                     zoom_up_q;
  logic signed [POS_W-1:0]  px_q;
  logic signed [POS_W-1:0]  py_q;
  logic signed [POS_W-1:0]  pz_q;
  logic [ANGLE_W-1:0]       heading_q;
  logic signed [POS_W:0]    h_q;
  logic signed [POS_W-1:0]  v_q;
  logic                     out_valid_q;
  out_t                     out_data_q;

  logic                     in_accept;
  logic                     can_load;
  logic                     load_out;
  logic                     wrap_start;
  logic                     mul_start;
  logic                     wrap_done;
  logic                     mul_done;
  logic                     pitch_done;
  logic                     orbit_done;
  logic                     mul0_done;
  logic                     mul1_done;

  logic signed [SUM_W-1:0]  dy_ext;
  logic signed [SUM_W-1:0]  dx_ext;
  logic signed [SUM_W-1:0]  pgain_ext;
  logic signed [SUM_W-1:0]  ogain_ext;
  logic signed [SUM_W-1:0]  pitch_prod;
  logic signed [SUM_W-1:0]  orbit_prod;
  logic signed [SUM_W-1:0]  pitch_sum;
  logic signed [SUM_W-1:0]  orbit_sum;
  logic [ANGLE_W-1:0]       pitch_new;
  logic [ANGLE_W-1:0]       orbit_new;

  logic signed [POS_W:0]    dn_wide;
  logic signed [POS_W:0]    up_wide;
  logic signed [POS_W-1:0]  dist_dn;
  logic signed [POS_W-1:0]  dist_up;

  logic [ANGLE_W-1:0]       head_red;
  logic [ANGLE_W:0]         theta_sum;
  logic [ANGLE_W-1:0]       theta;

  logic [ANGLE_W-1:0]       rom_ang_a;
  logic [ANGLE_W-1:0]       rom_ang_b;
  logic signed [SW-1:0]     sin_a;
  logic signed [SW-1:0]     sin_b;
  logic signed [POS_W:0]    mul_a_in;
  logic signed [POS_W:0]    mul0_res;
  logic signed [POS_W:0]    mul1_res;

  assign in_accept = in_valid_i && !in_stall_o;
  assign can_load  = !out_valid_q || !out_stall_i;
  assign wrap_done = pitch_done && orbit_done;
  assign mul_done  = mul0_done && mul1_done;

  assign dy_ext    = {{(SUM_W-16){in_data_i.mouse_dy[15]}}, in_data_i.mouse_dy};
  assign dx_ext    = {{(SUM_W-16){in_data_i.mouse_dx[15]}}, in_data_i.mouse_dx};
  assign pgain_ext = $signed(SUM_W'(pitch_gain_q));
  assign ogain_ext = $signed(SUM_W'(orbit_gain_q));
  assign pitch_prod = in_data_i.orbit_button ? dy_ext * pgain_ext : '0;
  assign orbit_prod = in_data_i.orbit_button ? dx_ext * ogain_ext : '0;
  assign pitch_sum  = $signed(SUM_W'(pitch_q)) + pitch_prod;
  assign orbit_sum  = $signed(SUM_W'(orbit_q)) - orbit_prod;

  assign dn_wide = {dist_q[POS_W-1], dist_q} - $signed((POS_W+1)'(zoom_step_q));
  assign up_wide = {dist_q[POS_W-1], dist_q} + $signed((POS_W+1)'(zoom_step_q));
  assign dist_dn = (dn_wide[POS_W] != dn_wide[POS_W-1]) ? {1'b1, {(POS_W-1){1'b0}}}
                                                        : dn_wide[POS_W-1:0];
  assign dist_up = (up_wide[POS_W] != up_wide[POS_W-1]) ? {1'b0, {(POS_W-1){1'b1}}}
                                                        : up_wide[POS_W-1:0];

  assign head_red  = (heading_q >= ANGLE_W'(FULL_TURN)) ? heading_q - ANGLE_W'(FULL_TURN)
                                                        : heading_q;
  assign theta_sum = {1'b0, head_red} + {1'b0, orbit_q};
  assign theta     = (theta_sum >= (ANGLE_W+1)'(FULL_TURN))
                     ? ANGLE_W'(theta_sum - (ANGLE_W+1)'(FULL_TURN))
                     : theta_sum[ANGLE_W-1:0];

  ocp_angle_wrap u_pitch_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .sum_i   (pitch_sum),
    .done_o  (pitch_done),
    .angle_o (pitch_new)
  );

  ocp_angle_wrap u_orbit_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .sum_i   (orbit_sum),
    .done_o  (orbit_done),
    .angle_o (orbit_new)
  );

  ocp_sine_rom #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_sine_rom (
    .clk_i     (clk_i),
    .angle_a_i (rom_ang_a),
    .angle_b_i (rom_ang_b),
    .sin_a_o   (sin_a),
    .sin_b_o   (sin_b)
  );

  ocp_serial_mul #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mul0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a_in),
    .b_i     (sin_a),
    .done_o  (mul0_done),
    .res_o   (mul0_res)
  );

  ocp_serial_mul #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a_in),
    .b_i     (sin_b),
    .done_o  (mul1_done),
    .res_o   (mul1_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_accept) state_d = ST_WRAP;
      ST_WRAP:      if (wrap_done) state_d = ST_TRIG_P;
      ST_TRIG_P:    state_d = ST_MUL_HV_GO;
      ST_MUL_HV_GO: state_d = ST_MUL_HV;
      ST_MUL_HV:    if (mul_done) state_d = ST_TRIG_T;
      ST_TRIG_T:    state_d = ST_MUL_T_GO;
      ST_MUL_T_GO:  state_d = ST_MUL_T;
      ST_MUL_T:     if (mul_done) state_d = ST_FINISH;
      ST_FINISH:    if (can_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // The first multiplier pass forms the horizontal distance and the lift, the second the
  // two horizontal offsets from the horizontal distance.
  always_comb begin
    in_stall_o = 1'b1;
    wrap_start = 1'b0;
    mul_start  = 1'b0;
    load_out   = 1'b0;
    rom_ang_a  = add_quarter(pitch_q);
    rom_ang_b  = pitch_q;
    mul_a_in   = {dist_q[POS_W-1], dist_q};
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        wrap_start = in_valid_i;
      end
      ST_MUL_HV_GO: begin
        mul_start = 1'b1;
      end
      ST_TRIG_T: begin
        rom_ang_a = theta;
        rom_ang_b = add_quarter(theta);
      end
      ST_MUL_T_GO: begin
        mul_start = 1'b1;
        mul_a_in  = h_q;
      end
      ST_FINISH: begin
        load_out = can_load;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      zoom_step_q  <= ZOOM_STEP_RST;
      pitch_gain_q <= PITCH_GAIN_RST;
      orbit_gain_q <= ORBIT_GAIN_RST;
      dist_q       <= DISTANCE_RST;
      pitch_q      <= PITCH_RST;
      orbit_q      <= ORBIT_RST;
      zoom_up_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_ZOOM_STEP:      zoom_step_q  <= cfg_data_i[15:0];
          CFG_PITCH_GAIN:     pitch_gain_q <= cfg_data_i[3:0];
          CFG_ORBIT_GAIN:     orbit_gain_q <= cfg_data_i[3:0];
          CFG_START_DISTANCE: dist_q       <= {1'b0, cfg_data_i};
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        zoom_up_q <= in_data_i.zoom_out_key;
        if (in_data_i.zoom_in_key) begin
          dist_q <= dist_dn;
        end
      end else if (state_q == ST_WRAP && zoom_up_q) begin
        zoom_up_q <= 1'b0;
        dist_q    <= dist_up;
      end
      if (state_q == ST_WRAP && wrap_done) begin
        pitch_q <= pitch_new;
        orbit_q <= orbit_new;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      px_q      <= in_data_i.player_x;
      py_q      <= in_data_i.player_y;
      pz_q      <= in_data_i.player_z;
      heading_q <= in_data_i.player_heading;
    end
    if (state_q == ST_MUL_HV && mul_done) begin
      h_q <= mul0_res;
      v_q <= mul1_res[POS_W-1:0];
    end
    if (load_out) begin
      out_data_q.camera_x <= px_q - mul0_res[POS_W-1:0];
      out_data_q.camera_y <= py_q + v_q;
      out_data_q.camera_z <= pz_q - mul1_res[POS_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/ocp_angle_wrap.sv]
// Serial reduction of an angle sum to the range 0 to 3599, one compare and subtract per cycle.
module ocp_angle_wrap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ocp_pkg::SUM_W-1:0]  sum_i,
  output logic                              done_o,
  output logic [ocp_pkg::ANGLE_W-1:0]       angle_o
);
  import ocp_pkg::*;

  localparam int VW = SUM_W - 1;
  localparam int KW = $clog2(WRAP_STEPS);

  logic                    busy_q;
  logic                    done_q;
  logic [KW-1:0]           k_q;
  logic [VW-1:0]           val_q;
  logic [VW-1:0]           val_d;
  logic [VW-1:0]           sub_val;
  logic signed [SUM_W-1:0] biased;

  // Adding 256 full turns keeps the value non-negative without changing it modulo a turn.
  assign biased  = sum_i + SUM_W'(FULL_TURN * (1 << WRAP_STEPS));
  assign sub_val = VW'(FULL_TURN) << k_q;

  always_comb begin
    if (start_i) begin
      val_d = sum_i[SUM_W-1] ? biased[VW-1:0] : sum_i[VW-1:0];
    end else if (busy_q && (val_q >= sub_val)) begin
      val_d = val_q - sub_val;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      k_q    <= KW'(WRAP_STEPS - 1);
    end else if (busy_q) begin
      if (k_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        k_q <= k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign done_o  = done_q;
  assign angle_o = val_q[ANGLE_W-1:0];

endmodule

[hw/rtl/ocp_sine_rom.sv]
// Quarter-wave sine table with two registered read ports and quadrant folding.
module ocp_sine_rom #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                clk_i,
  input  logic [ocp_pkg::ANGLE_W-1:0]         angle_a_i,
  input  logic [ocp_pkg::ANGLE_W-1:0]         angle_b_i,
  output logic signed [TRIG_FRAC_BITS+1:0]    sin_a_o,
  output logic signed [TRIG_FRAC_BITS+1:0]    sin_b_o
);
  import ocp_pkg::*;

  localparam int MW = TRIG_FRAC_BITS + 1;

  typedef logic [MW-1:0] entry_t;
  typedef entry_t        table_t [QUARTER+1];

  function automatic table_t build_table();
    table_t tb;
    for (int t = 0; t <= QUARTER; t++) begin
      tb[t] = entry_t'(sine_entry(t, TRIG_FRAC_BITS));
    end
    return tb;
  endfunction

  localparam table_t SINE_TABLE = build_table();

  typedef struct packed {
    logic                neg;
    logic [TABLE_AW-1:0] addr;
  } fold_t;

  function automatic fold_t fold(input logic [ANGLE_W-1:0] t);
    fold_t f;
    logic [ANGLE_W-1:0] d;
    if (t < ANGLE_W'(QUARTER)) begin
      d     = t;
      f.neg = 1'b0;
    end else if (t < ANGLE_W'(2 * QUARTER)) begin
      d     = ANGLE_W'(2 * QUARTER) - t;
      f.neg = 1'b0;
    end else if (t < ANGLE_W'(3 * QUARTER)) begin
      d     = t - ANGLE_W'(2 * QUARTER);
      f.neg = 1'b1;
    end else begin
      d     = ANGLE_W'(FULL_TURN) - t;
      f.neg = 1'b1;
    end
    f.addr = d[TABLE_AW-1:0];
    return f;
  endfunction

  fold_t  fold_a;
  fold_t  fold_b;
  entry_t mag_a_q;
  entry_t mag_b_q;
  logic   neg_a_q;
  logic   neg_b_q;

  assign fold_a = fold(angle_a_i);
  assign fold_b = fold(angle_b_i);

  always_ff @(posedge clk_i) begin
    mag_a_q <= SINE_TABLE[fold_a.addr];
    mag_b_q <= SINE_TABLE[fold_b.addr];
    neg_a_q <= fold_a.neg;
    neg_b_q <= fold_b.neg;
  end

  assign sin_a_o = neg_a_q ? -$signed({1'b0, mag_a_q}) : $signed({1'b0, mag_a_q});
  assign sin_b_o = neg_b_q ? -$signed({1'b0, mag_b_q}) : $signed({1'b0, mag_b_q});

endmodule

[hw/rtl/ocp_serial_mul.sv]
// Bit-serial signed multiplier of a position by a sine value, rounded half up to position format.
module ocp_serial_mul #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ocp_pkg::POS_W:0]    a_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  b_i,
  output logic                              done_o,
  output logic signed [ocp_pkg::POS_W:0]    res_o
);
  import ocp_pkg::*;

  localparam int SW   = TRIG_FRAC_BITS + 2;
  localparam int MAGW = TRIG_FRAC_BITS + 1;
  localparam int CW   = POS_W + 2;
  localparam int ACCW = CW + MAGW;
  localparam int CNTW = $clog2(MAGW + 1);

  logic [CNTW-1:0]        cnt_q;
  logic                   done_q;
  logic [MAGW-1:0]        mag_q;
  logic signed [CW-1:0]   mcand_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [SW-1:0]   b_abs;
  logic signed [CW-1:0]   a_ext;
  logic signed [ACCW-1:0] addend;
  logic signed [ACCW-1:0] rounded;

  assign b_abs  = b_i[SW-1] ? -b_i : b_i;
  assign a_ext  = {a_i[POS_W], a_i};
  assign addend = mag_q[MAGW-1] ? {{MAGW{mcand_q[CW-1]}}, mcand_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNTW'(MAGW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q   <= b_abs[MAGW-1:0];
      mcand_q <= b_i[SW-1] ? -a_ext : a_ext;
      acc_q   <= '0;
    end else if (cnt_q != '0) begin
      mag_q <= mag_q << 1;
      acc_q <= (acc_q <<< 1) + addend;
    end
  end

  assign rounded = acc_q + (ACCW'(1) << (TRIG_FRAC_BITS - 1));
  assign res_o   = rounded[TRIG_FRAC_BITS+POS_W:TRIG_FRAC_BITS];
  assign done_o  = done_q;

endmodule

[hw/rtl/ocp_checker.sv]
// Port-level checker of the orbit camera position unit and its bind to the top level.
module ocp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input ocp_pkg::out_t out_data_o
);
  import ocp_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // An accepted item keeps the unit busy and the input held off right after the transfer.
  a_busy_after_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o ##1 in_stall_o
  ) else $error("input not held off after a transfer");

  // A new result never appears right after an input transfer.
  a_no_instant_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o)
  ) else $error("result appeared one cycle after an input transfer");

  // A result is only produced at the end of a busy period.
  a_result_after_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without a busy period");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o)
  ) else $error("stalled result changed");

endmodule

bind orbit_camera_position_unit ocp_checker u_ocp_checker (.*);

[dv/tb.sv]
// Self-checking testbench of the orbit camera position unit with a frame driver and a camera predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ocp_pkg::*;

  localparam int TRIG_FRAC    = 15;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int FLOOD_FRAMES = 60;
  localparam int PHASE_FRAMES = 250;
  localparam int CALM_FRAMES  = 150;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  cfg_index_e  cfg_index_i = CFG_ZOOM_STEP;
  logic [30:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  orbit_camera_position_unit #(
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  longint      sine_tbl [0:QUARTER];
  logic [15:0] zoom_step  = ZOOM_STEP_RST;
  logic [3:0]  pitch_gain = PITCH_GAIN_RST;
  logic [3:0]  orbit_gain = ORBIT_GAIN_RST;
  int          distance   = int'(DISTANCE_RST);
  int          pitch      = int'(PITCH_RST);
  int          orbit      = int'(ORBIT_RST);

  in_t  frame_q  [$];
  out_t camera_q [$];
  out_t due;

  int   mismatches    = 0;
  int   frames_taken  = 0;
  int   settings_used = 0;
  int   idle_cycles   = 0;
  int   send_gap      = 0;
  int   stall_left    = 0;
  logic in_fire       = 1'b0;
  logic gaps_on       = 1'b1;
  logic hold_req      = 1'b0;
  logic hold_seen     = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void build_sine_table();
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    one = 64'd1 << 30;
    for (int t = 0; t <= QUARTER; t++) begin
      x  = (64'(t) * PI_Q30) / 64'd1800;
      x2 = (x * x) >> 30;
      r  = one;
      for (int n = 6; n >= 1; n--) begin
        r = one - ((r * x2) >> 30) / 64'(2 * n * (2 * n + 1));
      end
      s = (x * r) >> 30;
      s = (s + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
      if (s > (64'd1 << TRIG_FRAC)) begin
        s = 64'd1 << TRIG_FRAC;
      end
      sine_tbl[t] = longint'(s);
    end
  endfunction

  function automatic int turn_wrap(int a);
    int m;
    m = a % FULL_TURN;
    return (m < 0) ? m + FULL_TURN : m;
  endfunction

  function automatic longint sin_tenths(int a);
    int     t;
    int     q;
    int     r;
    longint v;
    t = turn_wrap(a);
    q = t / QUARTER;
    r = t % QUARTER;
    v = (q == 1 || q == 3) ? sine_tbl[QUARTER - r] : sine_tbl[r];
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint round_trig(longint p);
    return (p + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic out_t camera_of(in_t f);
    longint h;
    longint v;
    longint offx;
    longint offz;
    int     theta;
    out_t   o;
    if (f.zoom_in_key) begin
      distance = clamp32(longint'(distance) - longint'(zoom_step));
    end
    if (f.zoom_out_key) begin
      distance = clamp32(longint'(distance) + longint'(zoom_step));
    end
    if (f.orbit_button) begin
      pitch = turn_wrap(pitch + int'(f.mouse_dy) * int'(pitch_gain));
      orbit = turn_wrap(orbit - int'(f.mouse_dx) * int'(orbit_gain));
    end
    h     = round_trig(longint'(distance) * sin_tenths(pitch + QUARTER));
    v     = round_trig(longint'(distance) * sin_tenths(pitch));
    theta = turn_wrap(turn_wrap(int'(f.player_heading)) + orbit);
    offx  = round_trig(h * sin_tenths(theta));
    offz  = round_trig(h * sin_tenths(theta + QUARTER));
    o.camera_x = f.player_x - offx[31:0];
    o.camera_y = f.player_y + v[31:0];
    o.camera_z = f.player_z - offz[31:0];
    return o;
  endfunction

  function automatic in_t frame(input bit zi, zo, ob, input int dx, dy, x, y, z, hd);
    in_t f;
    f.zoom_in_key    = zi;
    f.zoom_out_key   = zo;
    f.orbit_button   = ob;
    f.mouse_dx       = 16'(dx);
    f.mouse_dy       = 16'(dy);
    f.player_x       = x;
    f.player_y       = y;
    f.player_z       = z;
    f.player_heading = 12'(hd);
    return f;
  endfunction

  function automatic in_t random_frame();
    in_t f;
    f.zoom_in_key  = ($urandom_range(3) == 0);
    f.zoom_out_key = ($urandom_range(3) == 0);
    f.orbit_button = $urandom_range(1);
    f.mouse_dx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200)) - 16'd100;
    f.mouse_dy = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200)) - 16'd100;
    f.player_x = ($urandom_range(3) == 0) ? 32'($urandom)
                                          : 32'($urandom_range(32'd13107200)) - 32'd6553600;
    f.player_y = ($urandom_range(3) == 0) ? 32'($urandom)
                                          : 32'($urandom_range(32'd13107200)) - 32'd6553600;
    f.player_z = ($urandom_range(3) == 0) ? 32'($urandom)
                                          : 32'($urandom_range(32'd13107200)) - 32'd6553600;
    f.player_heading = ($urandom_range(7) == 0) ? 12'($urandom_range(4095, 3600))
                                                : 12'($urandom_range(3599));
    return f;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 30) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  task automatic check_coord(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, $signed(got), $signed(want)));
    end
  endtask

  task automatic write_reg(cfg_index_e idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
  endtask

  task automatic load_settings(logic [15:0] zs, logic [3:0] pg, logic [3:0] og,
                               logic [30:0] sd);
    write_reg(CFG_ZOOM_STEP, 31'(zs));
    write_reg(CFG_PITCH_GAIN, 31'(pg));
    write_reg(CFG_ORBIT_GAIN, 31'(og));
    write_reg(CFG_START_DISTANCE, sd);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (frame_q.size() != 0 || in_valid_i || camera_q.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (frame_q.size() != 0 && gaps_on && $urandom_range(7) == 0) begin
        send_gap   <= $urandom_range(13, 1) - 1;
        in_valid_i <= 1'b0;
      end else if (frame_q.size() != 0) begin
        in_data_i  <= frame_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen   <= 1'b1;
      stall_left  <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (stall_left > 1) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (gaps_on && $urandom_range(9) == 0) begin
      stall_left  <= $urandom_range(13, 1);
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ZOOM_STEP:      zoom_step  = cfg_data_i[15:0];
          CFG_PITCH_GAIN:     pitch_gain = cfg_data_i[3:0];
          CFG_ORBIT_GAIN:     orbit_gain = cfg_data_i[3:0];
          CFG_START_DISTANCE: distance   = int'({1'b0, cfg_data_i});
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        camera_q.push_back(camera_of(in_data_i));
        frames_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (camera_q.size() == 0) begin
          report_mismatch("camera result with no frame awaiting it");
        end else begin
          due = camera_q.pop_front();
          check_coord("camera_x", out_data_o.camera_x, due.camera_x);
          check_coord("camera_y", out_data_o.camera_y, due.camera_y);
          check_coord("camera_z", out_data_o.camera_z, due.camera_z);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
      $display("orbit_camera_position_unit test failed");
      $finish;
    end
  end

  initial begin
    in_t f;
    build_sine_table();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    frame_q.push_back(frame(0, 0, 0, 0, 0, 0, 0, 0, 0));
    frame_q.push_back(frame(1, 0, 0, 0, 0, 65536, -65536, 0, 450));
    frame_q.push_back(frame(0, 1, 0, 0, 0, 0, 0, 65536, 1350));
    frame_q.push_back(frame(1, 1, 0, 0, 0, 0, 0, 0, 0));
    frame_q.push_back(frame(0, 0, 1, -32768, 32767, 0, 0, 0, 900));
    frame_q.push_back(frame(0, 0, 1, 32767, -32768, 0, 0, 0, 1800));
    frame_q.push_back(frame(0, 0, 1, 1, 1, 32'sh7fffffff, 32'sh80000000, -1, 2700));
    frame_q.push_back(frame(0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 3599));
    frame_q.push_back(frame(0, 0, 0, -1, -1, 0, 0, 0, 3600));
    frame_q.push_back(frame(0, 0, 1, -1, -1, 0, 0, 0, 4095));
    frame_q.push_back(frame(0, 0, 1, 0, -200, 0, 0, 0, 0));
    drain();

    load_settings(16'hffff, 4'hf, 4'hf, 31'h7fffffff);
    frame_q.push_back(frame(0, 1, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0));
    frame_q.push_back(frame(0, 1, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0));
    frame_q.push_back(frame(1, 1, 0, 0, 0, 0, 0, 0, 2000));
    frame_q.push_back(frame(0, 0, 1, -32768, -32768, 0, 0, 0, 3000));
    drain();

    load_settings(16'hffff, 4'hf, 4'hf, 31'd0);
    frame_q.push_back(frame(1, 0, 1, 100, 300, 0, 0, 0, 1234));
    frame_q.push_back(frame(0, 0, 1, -7, 9, 0, 0, 0, 2222));
    drain();

    gaps_on = 1'b0;
    for (int i = 0; i < FLOOD_FRAMES; i++) begin
      f = random_frame();
      f.zoom_in_key  = 1'b1;
      f.zoom_out_key = 1'b0;
      frame_q.push_back(f);
    end
    frame_q.push_back(frame(1, 1, 1, 5, 5, 0, 0, 0, 100));
    frame_q.push_back(frame(0, 1, 0, 0, 0, 0, 0, 0, 3700));
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: load_settings(16'd0, 4'd0, 4'd0, 31'd0);
        1: load_settings(16'hffff, 4'hf, 4'hf, 31'h7fffffff);
        2: load_settings(16'($urandom), 4'($urandom), 4'($urandom), 31'($urandom));
        3: load_settings(16'($urandom), 4'($urandom), 4'($urandom),
                         31'($urandom_range(32'd3276800)));
        default: load_settings(ZOOM_STEP_RST, PITCH_GAIN_RST, ORBIT_GAIN_RST,
                               DISTANCE_RST[30:0]);
      endcase
      gaps_on = (p != 4);
      for (int i = 0; i < ((p == 4) ? CALM_FRAMES : PHASE_FRAMES); i++) begin
        frame_q.push_back(random_frame());
      end
      if (p == 1) begin
        hold_req = 1'b1;
      end
      drain();
    end

    repeat (60) @(posedge clk_i);
    $display("Checked %0d frames under %0d register settings, covering the upper distance limit,",
             frames_taken, settings_used);
    $display("negative distances, out-of-range headings, random idling on both sides and a");
    $display("%0d-cycle output hold.", LONG_HOLD);
    if (mismatches == 0) begin
      $display("orbit_camera_position_unit test passed");
    end else begin
      $display("orbit_camera_position_unit test failed");
    end
    $finish;
  end

endmodule
